// ===== rtl/core/fsk_byte_symbol_transmitter_macros.svh =====
// assertion helpers for the fsk byte transmitter
`ifndef FSK_BYTE_SYMBOL_TRANSMITTER_MACROS_SVH
`define FSK_BYTE_SYMBOL_TRANSMITTER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define FBST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FBST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fbst_pkg.sv =====
package fbst_pkg;

	localparam int FIFO_DEPTH_DEF     = 8;
	localparam int BITS_PER_FRAME_DEF = 8;

	localparam int DIV_W   = 12;
	localparam int BYTE_W  = 8;
	localparam int LEVEL_W = 4;
	localparam int BITCNT_W = 4;
	localparam int CFG_ADDR_W = 2;

	localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(16);

	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_START   = 2'd2;

	localparam logic [1:0] TONE_NONE = 2'd0;
	localparam logic [1:0] TONE_SYNC = 2'd1;
	localparam logic [1:0] TONE_ZERO = 2'd2;
	localparam logic [1:0] TONE_ONE  = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] REG_LOW_DIV  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HIGH_DIV = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SYNC_DIV = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [BYTE_W-1:0] data_byte;
		logic              rx_busy;
	} fbst_in_t;

	typedef struct packed {
		logic [1:0]         tone_kind;
		logic [DIV_W-1:0]   tone_divider;
		logic               carrier_on;
		logic               accepted;
		logic               busy_res;
		logic [LEVEL_W-1:0] queue_level;
	} fbst_out_t;

endpackage

// ===== rtl/core/fsk_byte_symbol_transmitter.sv =====
// each result is registered into the output register, or into the skid entry while the output register waits
// throughput: one item per cycle while the skid entry is empty; the fifo ram and the sequencer update in a single pass
// a popped byte arrives from the ram in the cycle after the start, before it is first needed
// a two-entry output buffer (register plus skid) keeps input open while one result waits
// reset (arst_n low, asynchronous): fifo empty, sequencer idle, carrier off, dividers at 16
module fsk_byte_symbol_transmitter
	import fbst_pkg::*;
#(
	parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF,
	parameter int BITS_PER_FRAME = BITS_PER_FRAME_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [DIV_W-1:0]      cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  fbst_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fbst_out_t             out_data
);

`include "fsk_byte_symbol_transmitter_macros.svh"

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
	localparam logic [BITCNT_W-1:0] BITS_LAST = BITCNT_W'(BITS_PER_FRAME);

	logic [DIV_W-1:0] low_div_q, high_div_q, sync_div_q;

	logic [PTR_W-1:0]    rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic [BYTE_W-1:0]   shift_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic                sync_sent_q, final_due_q, frame_done_q, sending_q;
	logic                load_pending_q;

	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] shift_cur;

	logic in_xfer;
	logic do_enq, do_start, do_tick;

	logic [PTR_W-1:0]    rd_ptr_d, wr_ptr_d;
	logic [CNT_W-1:0]    count_d;
	logic [BYTE_W-1:0]   shift_d;
	logic [BITCNT_W-1:0] bit_cnt_d, bit_cnt_inc;
	logic                sync_sent_d, final_due_d, frame_done_d, sending_d;
	fbst_out_t           res;

	fbst_out_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      out_take;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_div_q  <= DIV_RESET;
			high_div_q <= DIV_RESET;
			sync_div_q <= DIV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LOW_DIV:  low_div_q  <= cfg_wdata;
				REG_HIGH_DIV: high_div_q <= cfg_wdata;
				REG_SYNC_DIV: sync_div_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid && !in_stall;

	assign do_enq   = in_xfer && (in_data.action == ACT_ENQUEUE) && (count_q < CNT_FULL);
	assign do_start = in_xfer && (in_data.action == ACT_START) && !sending_q
		&& !in_data.rx_busy && (count_q != '0);
	assign do_tick  = in_xfer && (in_data.action == ACT_TICK) && sending_q;

	fbst_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (do_enq),
		.waddr (wr_ptr_q),
		.wdata (in_data.data_byte),
		.re    (do_start),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// popped byte lands in the cycle after the start transfer
	assign shift_cur   = load_pending_q ? ram_rdata : shift_q;
	assign bit_cnt_inc = bit_cnt_q + BITCNT_W'(1);

	always_comb begin
		rd_ptr_d     = rd_ptr_q;
		wr_ptr_d     = wr_ptr_q;
		count_d      = count_q;
		shift_d      = shift_cur;
		bit_cnt_d    = bit_cnt_q;
		sync_sent_d  = sync_sent_q;
		final_due_d  = final_due_q;
		frame_done_d = frame_done_q;
		sending_d    = sending_q;
		res          = '0;

		if (do_enq) begin
			wr_ptr_d     = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			count_d      = count_q + CNT_W'(1);
			res.accepted = 1'b1;
		end

		if (do_start) begin
			rd_ptr_d     = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			count_d      = count_q - CNT_W'(1);
			shift_d      = '0;
			bit_cnt_d    = '0;
			sync_sent_d  = 1'b0;
			final_due_d  = 1'b0;
			frame_done_d = 1'b0;
			sending_d    = 1'b1;
		end

		if (do_tick) begin
			priority if (frame_done_q && !final_due_q) begin
				shift_d      = '0;
				bit_cnt_d    = '0;
				sync_sent_d  = 1'b0;
				final_due_d  = 1'b0;
				frame_done_d = 1'b0;
				sending_d    = 1'b0;
			end else if (!sync_sent_q) begin
				res.tone_kind    = TONE_SYNC;
				res.tone_divider = sync_div_q;
				sync_sent_d      = 1'b1;
				if (final_due_q) begin
					frame_done_d = 1'b1;
					final_due_d  = 1'b0;
					sync_sent_d  = 1'b0;
				end
			end else begin
				// lsb first
				if (shift_cur[0]) begin
					res.tone_kind    = TONE_ONE;
					res.tone_divider = high_div_q;
				end else begin
					res.tone_kind    = TONE_ZERO;
					res.tone_divider = low_div_q;
				end
				sync_sent_d = 1'b0;
				shift_d     = {1'b0, shift_cur[BYTE_W-1:1]};
				bit_cnt_d   = bit_cnt_inc;
				if (bit_cnt_inc == BITS_LAST) begin
					final_due_d = 1'b1;
				end
			end
		end

		res.carrier_on  = sending_d;
		res.busy_res    = sending_d;
		res.queue_level = LEVEL_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q       <= '0;
			wr_ptr_q       <= '0;
			count_q        <= '0;
			shift_q        <= '0;
			bit_cnt_q      <= '0;
			sync_sent_q    <= 1'b0;
			final_due_q    <= 1'b0;
			frame_done_q   <= 1'b0;
			sending_q      <= 1'b0;
			load_pending_q <= 1'b0;
		end else begin
			rd_ptr_q       <= rd_ptr_d;
			wr_ptr_q       <= wr_ptr_d;
			count_q        <= count_d;
			shift_q        <= shift_d;
			bit_cnt_q      <= bit_cnt_d;
			sync_sent_q    <= sync_sent_d;
			final_due_q    <= final_due_d;
			frame_done_q   <= frame_done_d;
			sending_q      <= sending_d;
			load_pending_q <= do_start;
		end
	end

	// output register with skid entry
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_xfer && out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= skid_valid_q || in_xfer || (out_valid_q && !out_take);
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`FBST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL, "fifo count beyond depth")
	`FBST_ASSERT_NOW(a_load_while_sending, load_pending_q, sending_q && !sync_sent_q,
		"byte load outside a fresh frame")
	`FBST_ASSERT_NOW(a_skid_order, skid_valid_q, out_valid_q, "skid entry without output entry")
	`FBST_ASSERT_NOW(a_final_due, final_due_q, sending_q && (bit_cnt_q == BITS_LAST),
		"final sync pending at wrong bit count")
	`FBST_ASSERT_NEXT(a_enq_count, do_enq && !do_start, count_q == $past(count_q) + CNT_W'(1),
		"enqueue did not raise fifo level")

endmodule

// ===== rtl/core/fbst_ram.sv =====
module fbst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import fbst_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 325;
	localparam int RANDOM_PHASES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [DIV_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	fbst_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fbst_out_t out_data;

	fsk_byte_symbol_transmitter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// transmitter model state
	logic [DIV_W-1:0] div_low = DIV_RESET;
	logic [DIV_W-1:0] div_high = DIV_RESET;
	logic [DIV_W-1:0] div_sync = DIV_RESET;
	logic [BYTE_W-1:0] byte_mem [FIFO_DEPTH_DEF];
	int byte_rd = 0;
	int byte_wr = 0;
	int byte_count = 0;
	logic [BYTE_W-1:0] shift_bits = '0;
	int bits_sent = 0;
	logic sync_out = 1'b0;
	logic closing_sync = 1'b0;
	logic frame_over = 1'b0;
	logic sending = 1'b0;

	fbst_in_t tx_items [$];
	fbst_out_t tone_expected [$];
	fbst_in_t slot_item = '0;
	logic slot_full = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int hold_left = 0;
	int hold_asks = 0;
	int hold_done = 0;
	int drv_gap_max = 3;
	int mon_gap_max = 3;
	int mismatch_count = 0;
	int cycle_count = 0;
	int items_queued = 0;

	function automatic void sequencer_clear();
		shift_bits = '0;
		bits_sent = 0;
		sync_out = 1'b0;
		closing_sync = 1'b0;
		frame_over = 1'b0;
		sending = 1'b0;
	endfunction

	function automatic fbst_out_t tone_predict(fbst_in_t item);
		fbst_out_t res;
		res = '0;
		case (item.action)
			ACT_ENQUEUE: begin
				if (byte_count < FIFO_DEPTH_DEF) begin
					byte_mem[byte_wr] = item.data_byte;
					byte_wr = (byte_wr + 1) % FIFO_DEPTH_DEF;
					byte_count++;
					res.accepted = 1'b1;
				end
			end
			ACT_TICK: begin
				if (sending) begin
					if (frame_over && !closing_sync) begin
						sequencer_clear();
					end else if (!sync_out) begin
						res.tone_kind = TONE_SYNC;
						res.tone_divider = div_sync;
						sync_out = 1'b1;
						if (closing_sync) begin
							frame_over = 1'b1;
							closing_sync = 1'b0;
							sync_out = 1'b0;
						end
					end else begin
						if (shift_bits[0]) begin
							res.tone_kind = TONE_ONE;
							res.tone_divider = div_high;
						end else begin
							res.tone_kind = TONE_ZERO;
							res.tone_divider = div_low;
						end
						sync_out = 1'b0;
						shift_bits = shift_bits >> 1;
						bits_sent++;
						if (bits_sent == BITS_PER_FRAME_DEF)
							closing_sync = 1'b1;
					end
				end
			end
			ACT_START: begin
				if (!sending && !item.rx_busy && byte_count != 0) begin
					sequencer_clear();
					shift_bits = byte_mem[byte_rd];
					byte_rd = (byte_rd + 1) % FIFO_DEPTH_DEF;
					byte_count--;
					sending = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.carrier_on = sending;
		res.busy_res = sending;
		res.queue_level = LEVEL_W'(byte_count);
		return res;
	endfunction

	task automatic check_tone(fbst_out_t got);
		fbst_out_t want;
		if (tone_expected.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result: %p", got);
		end else begin
			want = tone_expected.pop_front();
			if (got.tone_kind !== want.tone_kind || got.tone_divider !== want.tone_divider
					|| got.carrier_on !== want.carrier_on || got.accepted !== want.accepted
					|| got.busy_res !== want.busy_res || got.queue_level !== want.queue_level) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result mismatch: expected %p actual %p", want, got);
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				tone_expected.push_back(tone_predict(in_data));
				slot_full = 1'b0;
			end
			if (!slot_full) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (tx_items.size() != 0) begin
					slot_item = tx_items.pop_front();
					slot_full = 1'b1;
					send_wait = $urandom_range(0, drv_gap_max);
				end
			end
			in_valid <= slot_full;
			in_data <= slot_item;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_tone(out_data);
				recv_wait = $urandom_range(0, mon_gap_max);
			end
			if (hold_asks != hold_done) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_item(logic [1:0] action, logic [BYTE_W-1:0] data_byte, logic rx_busy);
		fbst_in_t item;
		item.action = action;
		item.data_byte = data_byte;
		item.rx_busy = rx_busy;
		tx_items.push_back(item);
		items_queued++;
	endtask

	task automatic add_noise();
		add_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
	endtask

	// enqueue up to two bytes, start, then usually tick through the frame with some noise mixed in
	task automatic add_frame();
		int n_bytes;
		int n_ticks;
		n_bytes = $urandom_range(0, 2);
		n_ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 22) : 18;
		repeat (n_bytes) add_item(ACT_ENQUEUE, 8'($urandom), 1'($urandom));
		add_item(ACT_START, 8'($urandom), $urandom_range(0, 9) == 0);
		repeat (n_ticks) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			add_item(ACT_TICK, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic wait_idle();
		while (tx_items.size() != 0 || slot_full || tone_expected.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_divider(logic [CFG_ADDR_W-1:0] idx, logic [DIV_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_LOW_DIV: div_low = value;
			REG_HIGH_DIV: div_high = value;
			REG_SYNC_DIV: div_sync = value;
			default: begin
			end
		endcase
	endtask

	task automatic set_dividers(logic [DIV_W-1:0] lo, logic [DIV_W-1:0] hi,
			logic [DIV_W-1:0] sy);
		write_divider(REG_LOW_DIV, lo);
		write_divider(REG_HIGH_DIV, hi);
		write_divider(REG_SYNC_DIV, sy);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int phase_start;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle corner cases, then one full frame at reset dividers
		add_item(ACT_TICK, 8'hFF, 1'b1);
		add_item(ACT_UNUSED, 8'hFF, 1'b1);
		add_item(ACT_START, 8'h00, 1'b0);
		add_item(ACT_ENQUEUE, 8'hA5, 1'b0);
		add_item(ACT_START, 8'h00, 1'b1);
		add_item(ACT_START, 8'h00, 1'b0);
		add_item(ACT_START, 8'h00, 1'b0);
		add_item(ACT_ENQUEUE, 8'h00, 1'b1);
		add_item(ACT_ENQUEUE, 8'hFF, 1'b0);
		repeat (18) add_item(ACT_TICK, 8'h00, 1'b0);
		wait_idle();

		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			case (p)
				1: set_dividers(12'hFFF, 12'hFFF, 12'hFFF);
				2: set_dividers(DIV_RESET, DIV_RESET, DIV_RESET);
				3: set_dividers(DIV_RESET, 12'hFFF, 12'($urandom_range(16, 4095)));
				default: set_dividers(12'($urandom_range(16, 4095)),
					12'($urandom_range(16, 4095)), 12'($urandom_range(16, 4095)));
			endcase
			case (p)
				1: begin drv_gap_max = 19; mon_gap_max = 19; end
				2: begin drv_gap_max = 0; mon_gap_max = 0; end
				3: begin drv_gap_max = 0; mon_gap_max = 19; end
				4: begin drv_gap_max = 19; mon_gap_max = 0; end
				5: begin drv_gap_max = 5; mon_gap_max = 5; end
				default: begin drv_gap_max = 19; mon_gap_max = 19; end
			endcase
			// long receiver hold while the sender keeps offering
			if (p == 2 || p == 3)
				hold_asks++;
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick <= 6) begin
					add_frame();
				end else if (pick == 7) begin
					repeat ($urandom_range(1, 10)) add_item(ACT_ENQUEUE, 8'($urandom), 1'($urandom));
				end else if (pick == 8) begin
					repeat ($urandom_range(1, 8)) add_noise();
				end else begin
					add_item(ACT_START, 8'($urandom), 1'b1);
					add_item(ACT_TICK, 8'($urandom), 1'($urandom));
				end
			end
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && tone_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== fsk_byte_symbol_transmitter.f =====
+incdir+rtl/core
rtl/core/fbst_pkg.sv
rtl/core/fbst_ram.sv
rtl/core/fsk_byte_symbol_transmitter.sv
sim/testbench.sv
